/* hw/rtl/conv3x3_image_filter_top_macros.svh */
// Assertion helpers for the 3x3 convolution block.
// Both expect clk and rst in scope at the point of use.
`ifndef CONV3X3_IMAGE_FILTER_TOP_MACROS_SVH
`define CONV3X3_IMAGE_FILTER_TOP_MACROS_SVH

// same-cycle implication
`define CNV3_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CNV3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/cnv3_pkg.sv */
package cnv3_pkg;

  localparam int unsigned COEF_BITS = 16;
  localparam int unsigned OUT_BITS  = 16;
  localparam int unsigned CFG_BITS  = 48;

  localparam logic [10:0] FRAME_WIDTH_RESET  = 11'd1024;
  localparam logic [12:0] FRAME_HEIGHT_RESET = 13'd1024;
  localparam logic [47:0] COEF_SIDE_RESET    = 48'd0;
  localparam logic [47:0] COEF_MID_RESET     = 48'd268435456;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_COLOR_MODE    = 3'd2,
    REG_COEF_LEFT     = 3'd3,
    REG_COEF_MID      = 3'd4,
    REG_COEF_RIGHT    = 3'd5
  } cfg_reg_t;

  // per-item control decided by the front end
  typedef struct packed {
    logic       emit;    // item produces an output pixel
    logic       last;    // that output closes the frame
    logic       wrap;    // output centered on the last column: right column is padding
    logic       gray;    // single-channel mode
    logic [2:0] row_ok;  // kernel rows inside the frame, top first
    logic [2:0] col_ok;  // kernel columns inside the frame, left first
  } item_ctl_t;

  typedef logic [47:0] coef_col_t;

  function automatic logic signed [COEF_BITS-1:0] coef_at(coef_col_t col, int row);
    return $signed(col[16*row +: 16]);
  endfunction

endpackage

/* hw/rtl/conv3x3_image_filter_top.sv */
// 3x3 convolution over a raster pixel stream, zero padding at the frame edges.
// Input channel: in_valid/in_stall with mode, red_in, green_in, blue_in. A pixel
// item (mode 0) carries data; a drain item (mode 1) flushes pending outputs once
// the frame's pixels are all in, and is dropped before that.
// Output channel: out_valid/out_stall with red_out, green_out, blue_out (signed)
// and last_of_frame on the final pixel of the frame.
// Output pixel k is triggered by input item k+W+1, so a frame needs W+1 drain
// items after its last pixel. From the accepted item to the output the path runs
// through queue, line store read and window, multiply, row sums, and final sum
// with saturation into the output register. One item per cycle is sustained
// while out_stall is low; the line store takes one write and one read each cycle,
// with a bypass for the same column, and all 27 multipliers work in parallel.
// The front takes items while the 4-entry queue has room; out_stall freezes the
// whole back pipeline, so stalls reach the input only once the queue fills.
// Reset (rst, synchronous) empties the pipeline and restores the identity kernel,
// 1024x1024 RGB. The line stores need no clearing pass: neighbors outside the
// frame are masked by position. Config writes (cfg_we, cfg_index, cfg_data) belong
// only to idle periods; writing frame_width or frame_height restarts the frame.
`include "conv3x3_image_filter_top_macros.svh"

module conv3x3_image_filter_top #(
  parameter int MAX_WIDTH      = 1024,
  parameter int COEF_FRAC_BITS = 12,
  parameter int CHANNEL_BITS   = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [2:0]                        cfg_index,
  input  logic [cnv3_pkg::CFG_BITS-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              mode,
  input  logic [CHANNEL_BITS-1:0]           red_in,
  input  logic [CHANNEL_BITS-1:0]           green_in,
  input  logic [CHANNEL_BITS-1:0]           blue_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [cnv3_pkg::OUT_BITS-1:0] red_out,
  output logic signed [cnv3_pkg::OUT_BITS-1:0] green_out,
  output logic signed [cnv3_pkg::OUT_BITS-1:0] blue_out,
  output logic                              last_of_frame
);
  import cnv3_pkg::*;

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int QDEPTH = 4;
  localparam int QW     = $bits(item_ctl_t) + CW + 3 * CHANNEL_BITS;

  logic [10:0] frame_width;
  logic [12:0] frame_height;
  logic        color_mode;
  logic [47:0] coef_left;
  logic [47:0] coef_mid;
  logic [47:0] coef_right;
  logic        restart;

  logic                      q_push;
  logic                      q_pop;
  logic                      q_full;
  logic                      q_empty;
  item_ctl_t                 f_ctl;
  logic [CW-1:0]             f_col;
  logic [3*CHANNEL_BITS-1:0] f_px;
  item_ctl_t                 b_ctl;
  logic [CW-1:0]             b_col;
  logic [3*CHANNEL_BITS-1:0] b_px;

  assign restart = cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
      color_mode   <= 1'b1;
      coef_left    <= COEF_SIDE_RESET;
      coef_mid     <= COEF_MID_RESET;
      coef_right   <= COEF_SIDE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[10:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[12:0];
        REG_COLOR_MODE:   color_mode   <= cfg_data[0];
        REG_COEF_LEFT:    coef_left    <= cfg_data;
        REG_COEF_MID:     coef_mid     <= cfg_data;
        REG_COEF_RIGHT:   coef_right   <= cfg_data;
        default:          frame_width  <= frame_width;
      endcase
    end
  end

  cnv3_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .CHANNEL_BITS (CHANNEL_BITS),
    .CW           (CW)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .color_mode   (color_mode),
    .restart      (restart),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_ctl        (f_ctl),
    .q_col        (f_col),
    .q_px         (f_px)
  );

  cnv3_fifo #(
    .WIDTH (QW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata ({f_ctl, f_col, f_px}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata ({b_ctl, b_col, b_px}),
    .empty (q_empty)
  );

  cnv3_back #(
    .MAX_WIDTH      (MAX_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .CHANNEL_BITS   (CHANNEL_BITS),
    .CW             (CW)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_ready       (!q_empty),
    .q_pop         (q_pop),
    .q_ctl         (b_ctl),
    .q_col         (b_col),
    .q_px          (b_px),
    .coef_left     (coef_left),
    .coef_mid      (coef_mid),
    .coef_right    (coef_right),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .red_out       (red_out),
    .green_out     (green_out),
    .blue_out      (blue_out),
    .last_of_frame (last_of_frame)
  );

  `CNV3_ASSERT_NOW(a_push_room, q_push, !q_full, "item pushed into a full queue")
  `CNV3_ASSERT_NOW(a_pop_data, q_pop, !q_empty, "item popped from an empty queue")
  `CNV3_ASSERT_NOW(a_gray_zero, out_valid && !color_mode, green_out == '0 && blue_out == '0, "gray output carries color")
  `CNV3_ASSERT_NEXT(a_queue_idle, q_empty && !q_push, q_empty, "queue filled without a push")

endmodule

/* hw/rtl/cnv3_fifo.sv */
module cnv3_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;

  assign full  = (count == CNTW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNTW'(1);
        2'b01:   count <= count - CNTW'(1);
        default: count <= count;
      endcase
    end
  end
endmodule

/* hw/rtl/cnv3_front.sv */
module cnv3_front #(
  parameter int MAX_WIDTH    = 1024,
  parameter int CHANNEL_BITS = 8,
  parameter int CW           = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      mode,
  input  logic [CHANNEL_BITS-1:0]   red_in,
  input  logic [CHANNEL_BITS-1:0]   green_in,
  input  logic [CHANNEL_BITS-1:0]   blue_in,
  input  logic [10:0]               frame_width,
  input  logic [12:0]               frame_height,
  input  logic                      color_mode,
  input  logic                      restart,
  input  logic                      q_full,
  output logic                      q_push,
  output cnv3_pkg::item_ctl_t       q_ctl,
  output logic [CW-1:0]             q_col,
  output logic [3*CHANNEL_BITS-1:0] q_px
);
  import cnv3_pkg::*;

  logic [CW-1:0]     col;
  logic [13:0]       row;
  logic [10:0]       w_eff;
  logic [12:0]       h_eff;
  logic [13:0]       col_ext;
  logic              accept;
  logic              flush;
  logic              drop;
  logic              c0;
  logic              wrap_row;
  logic signed [15:0] y_base;
  logic signed [15:0] yy [3];
  item_ctl_t         ctl;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    if (frame_width == 11'd0) begin
      w_eff = 11'd1;
    end else if ({21'd0, frame_width} > 32'(MAX_WIDTH)) begin
      w_eff = 11'(MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    h_eff = (frame_height == 13'd0) ? 13'd1 : frame_height;
  end

  assign col_ext  = 14'(col);
  assign c0       = (col == '0);
  assign flush    = (row >= {1'b0, h_eff});
  assign drop     = !flush && mode;
  assign wrap_row = (col_ext + 14'd1 >= {3'd0, w_eff});
  // output row lies two rows back when centered on the previous row's last column
  assign y_base   = $signed({2'b00, row}) - (c0 ? 16'sd3 : 16'sd2);

  always_comb begin
    ctl.emit = (row >= 14'd2) || (row == 14'd1 && !c0);
    ctl.last = ctl.emit && c0 && (row == {1'b0, h_eff} + 14'd1);
    ctl.wrap = c0;
    ctl.gray = !color_mode;
    for (int i = 0; i < 3; i++) begin
      yy[i] = y_base + 16'(i);
      ctl.row_ok[i] = !yy[i][15] && (yy[i] < $signed({3'b000, h_eff}));
    end
    ctl.col_ok[0] = c0 ? (w_eff >= 11'd2) : (col_ext >= 14'd2);
    ctl.col_ok[1] = 1'b1;
    ctl.col_ok[2] = !c0;
  end

  assign q_push = accept && !drop;
  assign q_ctl  = ctl;
  assign q_col  = col;
  assign q_px   = flush ? '0 :
                  {(color_mode ? blue_in : '0), (color_mode ? green_in : '0), red_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (restart) begin
      col <= '0;
      row <= '0;
    end else if (q_push) begin
      if (ctl.last) begin
        col <= '0;
        row <= '0;
      end else if (wrap_row) begin
        col <= '0;
        row <= row + 14'd1;
      end else begin
        col <= col + CW'(1);
      end
    end
  end
endmodule

/* hw/rtl/cnv3_back.sv */
module cnv3_back #(
  parameter int MAX_WIDTH      = 1024,
  parameter int COEF_FRAC_BITS = 12,
  parameter int CHANNEL_BITS   = 8,
  parameter int CW             = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_ready,
  output logic                              q_pop,
  input  cnv3_pkg::item_ctl_t               q_ctl,
  input  logic [CW-1:0]                     q_col,
  input  logic [3*CHANNEL_BITS-1:0]         q_px,
  input  logic [47:0]                       coef_left,
  input  logic [47:0]                       coef_mid,
  input  logic [47:0]                       coef_right,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [cnv3_pkg::OUT_BITS-1:0] red_out,
  output logic signed [cnv3_pkg::OUT_BITS-1:0] green_out,
  output logic signed [cnv3_pkg::OUT_BITS-1:0] blue_out,
  output logic                              last_of_frame
);
  import cnv3_pkg::*;

  localparam int CB   = CHANNEL_BITS;
  localparam int P    = 3 * CB;
  localparam int PW   = CB + 1 + COEF_BITS;
  localparam int TW   = PW - COEF_FRAC_BITS;
  localparam int RW   = TW + 2;
  localparam int SW   = TW + 4;
  localparam int EW   = (SW > 17) ? SW : 17;
  localparam logic signed [EW-1:0] SAT_HI = EW'(32767);
  localparam logic signed [EW-1:0] SAT_LO = -EW'(32768);
  localparam logic [PW-1:0] ROUND_ADJ = PW'((1 << COEF_FRAC_BITS) - 1);

  logic adv;

  // stage A: line store read
  logic            a_v;
  item_ctl_t       a_ctl;
  logic [CW-1:0]   a_col;
  logic [P-1:0]    a_px;
  logic [2*P-1:0]  lines [MAX_WIDTH];
  logic [2*P-1:0]  rd_data;
  logic [2*P-1:0]  wr_data;
  logic            fwd;
  logic [P-1:0]    new_col [3];

  // window, rows top to bottom, columns left to right
  logic [P-1:0]    win [3][3];

  // stage B: masked neighborhood
  logic            b_v;
  logic            b_last;
  logic            b_gray;
  logic [P-1:0]    b_eff [3][3];
  logic [P-1:0]    eff [3][3];

  // stage C: products
  logic            c_v;
  logic            c_last;
  logic            c_gray;
  logic signed [PW-1:0] c_prod [3][3][3];

  // stage D: row sums of truncated terms
  logic            d_v;
  logic            d_last;
  logic            d_gray;
  logic signed [RW-1:0] d_row [3][3];

  coef_col_t       coef_cols [3];
  logic signed [TW-1:0] term [3][3][3];
  logic signed [EW-1:0] total [3];
  logic signed [OUT_BITS-1:0] sat [3];

  assign adv   = !out_valid || !out_stall;
  assign q_pop = adv && q_ready;

  assign coef_cols[0] = coef_left;
  assign coef_cols[1] = coef_mid;
  assign coef_cols[2] = coef_right;

  // entry packs {two rows back, one row back}
  assign wr_data    = {rd_data[P-1:0], a_px};
  assign fwd        = a_v && (q_col == a_col);
  assign new_col[0] = rd_data[2*P-1:P];
  assign new_col[1] = rd_data[P-1:0];
  assign new_col[2] = a_px;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (a_v) begin
        lines[a_col] <= wr_data;
      end
      // bypass the write to the same column
      rd_data <= fwd ? wr_data : lines[q_col];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ctl <= q_ctl;
      a_col <= q_col;
      a_px  <= q_px;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eff[i][0] = (a_ctl.row_ok[i] && a_ctl.col_ok[0]) ? win[i][1] : '0;
      eff[i][1] = (a_ctl.row_ok[i] && a_ctl.col_ok[1]) ? win[i][2] : '0;
      eff[i][2] = (a_ctl.row_ok[i] && a_ctl.col_ok[2] && !a_ctl.wrap) ? new_col[i] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && a_v) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
        win[i][2] <= new_col[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_last <= a_ctl.last;
      b_gray <= a_ctl.gray;
      b_eff  <= eff;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_last <= b_last;
      c_gray <= b_gray;
      for (int ch = 0; ch < 3; ch++) begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            c_prod[ch][i][j] <= PW'($signed({1'b0, b_eff[i][j][ch*CB +: CB]})
                                   * coef_at(coef_cols[j], i));
          end
        end
      end
    end
  end

  // truncate toward zero: bias negatives before the arithmetic shift
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          term[ch][i][j] = TW'((c_prod[ch][i][j]
                              + $signed(c_prod[ch][i][j][PW-1] ? ROUND_ADJ : '0))
                              >>> COEF_FRAC_BITS);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_last <= c_last;
      d_gray <= c_gray;
      for (int ch = 0; ch < 3; ch++) begin
        for (int i = 0; i < 3; i++) begin
          d_row[ch][i] <= RW'(term[ch][i][0]) + RW'(term[ch][i][1]) + RW'(term[ch][i][2]);
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      total[ch] = EW'(d_row[ch][0]) + EW'(d_row[ch][1]) + EW'(d_row[ch][2]);
      if (total[ch] > SAT_HI) begin
        sat[ch] = 16'sh7fff;
      end else if (total[ch] < SAT_LO) begin
        sat[ch] = -16'sh8000;
      end else begin
        sat[ch] = OUT_BITS'(total[ch]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red_out       <= sat[0];
      green_out     <= d_gray ? '0 : sat[1];
      blue_out      <= d_gray ? '0 : sat[2];
      last_of_frame <= d_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      c_v       <= 1'b0;
      d_v       <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      a_v       <= q_ready;
      b_v       <= a_v && a_ctl.emit;
      c_v       <= b_v;
      d_v       <= c_v;
      out_valid <= d_v;
    end
  end
endmodule

/* tb/sv/tb_conv3x3_image_filter_top.sv */
`default_nettype none

module tb_conv3x3_image_filter_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cnv3_pkg::*;

  localparam int MAXW = 1024;
  localparam int FRAC = 12;

  typedef struct {
    logic       mode;
    logic [7:0] r, g, b;
  } pix_item_t;

  typedef struct {
    logic [15:0] r, g, b;
    logic        last;
  } filt_pix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_FRAME_WIDTH;
  logic [CFG_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode = 1'b0;
  logic [7:0] red_in = '0, green_in = '0, blue_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] red_out, green_out, blue_out;
  logic last_of_frame;

  conv3x3_image_filter_top u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
    .last_of_frame(last_of_frame)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // filter state mirrored in the testbench
  logic [7:0] row1_store[MAXW][3];
  logic [7:0] row2_store[MAXW][3];
  logic [7:0] win[3][3][3];
  int unsigned col_pos, row_pos, out_count;
  logic [10:0] f_width;
  logic [12:0] f_height;
  logic        rgb;
  logic [47:0] coef_col[3];

  pix_item_t pending_q[$];
  filt_pix_t filtered_q[$];
  int errors = 0;
  int n_queued = 0;
  bit gaps_on = 1'b1;
  bit in_took = 1'b0;
  int in_gap = 0;
  int out_hold = 0;

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, $signed(got),
             $signed(want), $realtime);
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (!gaps_on || p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void apply_cfg(logic [2:0] idx, logic [47:0] d);
    case (idx)
      REG_FRAME_WIDTH:  f_width = d[10:0];
      REG_FRAME_HEIGHT: f_height = d[12:0];
      REG_COLOR_MODE:   rgb = d[0];
      REG_COEF_LEFT:    coef_col[0] = d;
      REG_COEF_MID:     coef_col[1] = d;
      REG_COEF_RIGHT:   coef_col[2] = d;
      default: ;
    endcase
    if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) begin
      col_pos = 0;
      row_pos = 0;
      out_count = 0;
    end
  endfunction

  function automatic void filter_step(pix_item_t it);
    int unsigned w, h, c, r;
    logic [7:0] px[3];
    logic [7:0] eff[3][3][3];
    bit flushing, emit;
    int ox, oy, yy, xx, cf, prod;
    int sum[3];
    filt_pix_t o;
    w = (f_width == 0) ? 1 : (f_width > MAXW) ? MAXW : int'(f_width);
    h = (f_height == 0) ? 1 : int'(f_height);
    c = (col_pos >= w) ? 0 : col_pos;
    r = row_pos;
    flushing = (r >= h);
    if (!flushing && it.mode) return;
    px = '{8'd0, 8'd0, 8'd0};
    if (!flushing) begin
      px[0] = it.r;
      if (rgb) begin
        px[1] = it.g;
        px[2] = it.b;
      end
    end
    emit = (r >= 2) || (r == 1 && c >= 1);
    // at column zero the output sits on the last column two rows up
    if (c == 0) begin
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 3; k++) begin
          eff[i][0][k] = win[i][1][k];
          eff[i][1][k] = win[i][2][k];
          eff[i][2][k] = 0;
        end
      ox = int'(w) - 1;
      oy = int'(r) - 2;
    end else begin
      ox = int'(c) - 1;
      oy = int'(r) - 1;
    end
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0][k] = win[i][1][k];
        win[i][1][k] = win[i][2][k];
      end
      win[0][2][k] = row2_store[c][k];
      win[1][2][k] = row1_store[c][k];
      win[2][2][k] = px[k];
      row2_store[c][k] = row1_store[c][k];
      row1_store[c][k] = px[k];
    end
    if (c != 0) eff = win;
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
    end
    if (!emit) return;
    for (int k = 0; k < 3; k++) begin
      sum[k] = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          yy = oy - 1 + i;
          xx = ox - 1 + j;
          if (yy < 0 || yy >= int'(h) || xx < 0 || xx >= int'(w)) continue;
          cf = int'($signed(coef_col[j][16*i +: 16]));
          prod = int'(eff[i][j][k]) * cf;
          // truncate toward zero
          sum[k] += (prod < 0) ? -((-prod) >>> FRAC) : (prod >>> FRAC);
        end
      if (sum[k] > 32767) sum[k] = 32767;
      if (sum[k] < -32768) sum[k] = -32768;
      if (!rgb && k != 0) sum[k] = 0;
    end
    o.r = sum[0][15:0];
    o.g = sum[1][15:0];
    o.b = sum[2][15:0];
    out_count++;
    o.last = (out_count >= w * h);
    if (o.last) begin
      col_pos = 0;
      row_pos = 0;
      out_count = 0;
    end
    filtered_q = {filtered_q, o};
  endfunction

  // acceptance, prediction and checking
  always @(posedge clk) begin
    filt_pix_t e;
    in_took = in_valid && !in_stall && !rst;
    if (rst) begin
      col_pos = 0;
      row_pos = 0;
      out_count = 0;
      f_width = FRAME_WIDTH_RESET;
      f_height = FRAME_HEIGHT_RESET;
      rgb = 1'b1;
      coef_col[0] = COEF_SIDE_RESET;
      coef_col[1] = COEF_MID_RESET;
      coef_col[2] = COEF_SIDE_RESET;
    end else begin
      if (cfg_we) apply_cfg(cfg_index, cfg_data);
      if (in_took) filter_step('{mode, red_in, green_in, blue_in});
      if (out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          errors++;
          $display("MISMATCH unexpected output pixel at %0t", $realtime);
        end else begin
          e = filtered_q.pop_front();
          if (red_out !== e.r) report("red_out", red_out, e.r);
          if (green_out !== e.g) report("green_out", green_out, e.g);
          if (blue_out !== e.b) report("blue_out", blue_out, e.b);
          if (last_of_frame !== e.last)
            report("last_of_frame", {15'd0, last_of_frame}, {15'd0, e.last});
        end
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    pix_item_t it;
    if (!rst && (!in_valid || in_took)) begin
      if (in_took) in_gap = gap_len();
      if (in_gap > 0 || pending_q.size() == 0) begin
        if (in_gap > 0) in_gap--;
        in_valid <= 1'b0;
      end else begin
        it = pending_q.pop_front();
        in_valid <= 1'b1;
        mode <= it.mode;
        red_in <= it.r;
        green_in <= it.g;
        blue_in <= it.b;
      end
    end
  end

  // output stall generator
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_hold--;
      out_stall <= 1'b1;
    end else begin
      out_hold = gap_len();
      out_stall <= (out_hold > 0);
      if (out_hold > 0) out_hold--;
    end
  end

  task automatic wait_idle();
    wait (pending_q.size() == 0 && !in_valid && filtered_q.size() == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t idx, logic [47:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic setup(logic [10:0] w, logic [12:0] h, bit color,
                       logic [47:0] cl, logic [47:0] cm, logic [47:0] cr);
    wait_idle();
    cfg_write(REG_COLOR_MODE, {47'd0, color});
    cfg_write(REG_COEF_LEFT, cl);
    cfg_write(REG_COEF_MID, cm);
    cfg_write(REG_COEF_RIGHT, cr);
    cfg_write(REG_FRAME_WIDTH, {37'd0, w});
    cfg_write(REG_FRAME_HEIGHT, {35'd0, h});
  endtask

  function automatic pix_item_t rand_pix(bit drain);
    pix_item_t it;
    it.mode = drain;
    it.r = 8'($urandom);
    it.g = 8'($urandom);
    it.b = 8'($urandom);
    return it;
  endfunction

  function automatic logic [47:0] rand_coefs();
    logic [47:0] v;
    v = 48'({$urandom, $urandom});
    for (int i = 0; i < 3; i++)
      case ($urandom_range(0, 7))
        0: v[16*i +: 16] = 16'h8000;
        1: v[16*i +: 16] = 16'h7fff;
        2: v[16*i +: 16] = 16'h1000;
        3: v[16*i +: 16] = 16'hf000;
        default: ;
      endcase
    return v;
  endfunction

  function automatic void enqueue(pix_item_t it);
    pending_q = {pending_q, it};
    n_queued++;
  endfunction

  // queue one frame; noise adds ignored drains, pixels past the end act as drains
  task automatic push_frame(int w, int h, bit noise, int pix_cnt);
    for (int i = 0; i < pix_cnt; i++) begin
      if (noise && $urandom_range(0, 9) == 0) enqueue(rand_pix(1'b1));
      enqueue(rand_pix(1'b0));
    end
    if (pix_cnt == w * h)
      for (int i = 0; i <= w; i++)
        enqueue(rand_pix(noise ? $urandom_range(0, 3) != 0 : 1'b1));
  endtask

  initial begin
    int w, h;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: identity kernel at reset values on a small frame
    cfg_write(REG_FRAME_WIDTH, 48'd3);
    cfg_write(REG_FRAME_HEIGHT, 48'd2);
    enqueue('{1'b1, 8'hff, 8'hff, 8'hff});
    enqueue('{1'b0, 8'hff, 8'h00, 8'hff});
    enqueue('{1'b0, 8'h00, 8'hff, 8'h00});
    push_frame(3, 2, 1'b0, 4);
    setup(11'd1, 13'd1, 1'b1, 48'h8000_8000_8000, 48'h7fff_7fff_7fff, 48'h8000_8000_8000);
    enqueue('{1'b0, 8'hff, 8'hff, 8'hff});
    enqueue('{1'b0, 8'h00, 8'h00, 8'h00});
    enqueue('{1'b1, 8'h00, 8'h00, 8'h00});
    setup(11'd0, 13'd0, 1'b0, 48'h7fff_7fff_7fff, 48'h8000_8000_8000, 48'h7fff_7fff_7fff);
    push_frame(1, 1, 1'b1, 1);
    setup(11'd3, 13'd3, 1'b0, 48'h0001_ffff_8001, 48'hffff_0001_7ffe, 48'h1000_f000_0800);
    push_frame(3, 3, 1'b1, 9);
    // abort part way through a frame
    setup(11'd4, 13'd3, 1'b1, rand_coefs(), rand_coefs(), rand_coefs());
    push_frame(4, 3, 1'b0, 7);

    // extreme sizes, run without gaps
    gaps_on = 1'b0;
    // width above the line store depth clamps to it; abort after a short burst
    setup(11'd2047, 13'd2, 1'b0, rand_coefs(), rand_coefs(), rand_coefs());
    push_frame(1024, 2, 1'b0, 30);
    setup(11'd1, 13'd120, 1'b1, rand_coefs(), rand_coefs(), rand_coefs());
    push_frame(1, 120, 1'b0, 120);
    setup(11'd2, 13'd8191, 1'b1, rand_coefs(), rand_coefs(), rand_coefs());
    push_frame(2, 8191, 1'b0, 60);
    gaps_on = 1'b1;

    // random frames
    while (n_queued < 550) begin
      w = $urandom_range(0, 9) == 0 ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      setup(11'(w), 13'(h), 1'($urandom_range(0, 1)),
            rand_coefs(), rand_coefs(), rand_coefs());
      gaps_on = $urandom_range(0, 4) != 0;
      if ($urandom_range(0, 9) == 0) push_frame(w, h, 1'b1, $urandom_range(0, w * h - 1));
      else push_frame(w, h, 1'b1, w * h);
      // a few frames run back to back without reconfiguring
      if ($urandom_range(0, 3) == 0) push_frame(w, h, 1'b0, w * h);
    end
    gaps_on = 1'b1;

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0 && filtered_q.size() == 0) begin
      $display("tb_conv3x3_image_filter_top passed");
    end else begin
      $display("tb_conv3x3_image_filter_top failed");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("tb_conv3x3_image_filter_top failed");
    $finish;
  end

endmodule

`default_nettype wire
